[rtl/core/pirl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pirl_pkg
// Command and status codes plus the control and status bundles shared by the
// controller and the datapath of the positional insert/remove list.
// ----------------------------------------------------------------------------
package pirl_pkg;

  // Command codes carried in the command field
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;       // capture the incoming command
    logic       ptr_init;   // set the shift read pointer
    logic       rd_step;    // read at the pointer and move it one place
    logic       rd_idx;     // read at the command index
    logic       wr_shift;   // write the last read word one place over
    logic       wr_val;     // write the command value at the index
    logic       cnt_inc;
    logic       cnt_dec;
    logic       post;       // load the result register
    logic [1:0] status;
    logic       use_rdata;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] op;
    logic       ins_bad;    // insert index above count
    logic       acc_bad;    // remove/read index at or above count
    logic       full;
    logic       shift_need;
    logic       last_step;
  } sts_t;

endpackage : pirl_pkg
`default_nettype wire

[rtl/core/positional_insert_remove_list.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_insert_remove_list
// Ordered list of up to DEPTH words with insert, remove and read by position.
// ----------------------------------------------------------------------------
// Each command takes one input transfer and yields one result transfer with
// status, read data and the count after the command. The list lives in a
// memory with one write and one read port, and the shift of later entries
// moves one entry per cycle, so the cost of a command depends on how many
// entries lie beyond its index. Insert moves the entries at and above its
// index up one place and then writes the value, or only writes it when
// appending; remove moves the entries above its index down one place, or
// only lowers the count when removing the last entry; read and any rejected
// command move nothing. A new command is taken while the previous result
// still waits on the output register; a command finishes only once that
// register is free. Entries that were never written hold no defined value;
// only positions below the count are ever read.
// ----------------------------------------------------------------------------
module positional_insert_remove_list #(
  parameter int DEPTH      = 64,
  parameter int WORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [6:0]  in_index,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_read_value,
  output logic [6:0]  out_count
);
  import pirl_pkg::*;

  ctl_t ctl;
  sts_t sts;

  pirl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  pirl_dpath #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .sts            (sts),
    .in_command     (in_command),
    .in_index       (in_index),
    .in_value       (in_value),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_count      (out_count)
  );

  // single write port: shift write and value write never collide
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.wr_shift && ctl.wr_val))
    else $error("shift write and value write in the same cycle");

  a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.post && (ctl.status == ST_FULL)) |-> (sts.op == CMD_INSERT))
    else $error("full status posted for a command other than insert");

  a_no_early_post: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !ctl.post)
    else $error("result posted in the cycle after a transfer was taken");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.cnt_inc && ctl.cnt_dec))
    else $error("count raised and lowered together");

endmodule : positional_insert_remove_list
`default_nettype wire

[rtl/core/pirl_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pirl_dpath
// List storage, entry count, shift pointers and the result register. Moves
// one entry per cycle through a memory with one write and one read port.
// ----------------------------------------------------------------------------
module pirl_dpath #(
  parameter int DEPTH      = 64,
  parameter int WORD_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pirl_pkg::ctl_t       ctl,
  output pirl_pkg::sts_t       sts,
  input  logic [1:0]           in_command,
  input  logic [6:0]           in_index,
  input  logic [31:0]          in_value,
  output logic [1:0]           out_status,
  output logic [31:0]          out_read_value,
  output logic [6:0]           out_count
);
  import pirl_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = ((CW > 7) ? CW : 7) + 1;

  logic [WORD_WIDTH-1:0] mem [DEPTH];

  logic [1:0]            op_r;
  logic [6:0]            idx_r;
  logic [WORD_WIDTH-1:0] val_r;
  logic [CW-1:0]         cnt_r;
  logic [CW-1:0]         cnt_nxt;
  logic [AW-1:0]         ptr_r;
  logic [AW-1:0]         wptr_r;
  logic [WORD_WIDTH-1:0] rdata_r;
  logic [1:0]            out_status_r;
  logic [31:0]           out_read_value_r;
  logic [6:0]            out_count_r;

  logic [IW-1:0]         idx_ext;
  logic [IW-1:0]         cnt_ext;
  logic [IW-1:0]         idx_p1;
  logic [CW-1:0]         cnt_m1;
  logic [AW-1:0]         idx_a;
  logic [AW-1:0]         ptr_start;
  logic [AW-1:0]         raddr;
  logic [AW-1:0]         waddr;
  logic [WORD_WIDTH-1:0] wdata;
  logic                  rd_en;
  logic                  wr_en;
  logic                  is_ins;
  logic [63:0]           val_ext;
  logic [63:0]           rd_ext;

  assign is_ins  = (op_r == CMD_INSERT);
  assign idx_ext = IW'(idx_r);
  assign cnt_ext = IW'(cnt_r);
  assign idx_p1  = idx_ext + IW'(1);
  assign cnt_m1  = cnt_r - CW'(1);
  assign idx_a   = AW'(idx_r);

  always_comb begin
    sts.op         = op_r;
    sts.ins_bad    = (idx_ext > cnt_ext);
    sts.acc_bad    = (idx_ext >= cnt_ext);
    sts.full       = (cnt_r == CW'(DEPTH));
    sts.shift_need = is_ins ? (idx_ext < cnt_ext) : (idx_p1 < cnt_ext);
    sts.last_step  = is_ins ? (ptr_r == idx_a) : (ptr_r == AW'(cnt_m1));
  end

  // Insert walks down from the top entry, remove walks up from above the index
  assign ptr_start = is_ins ? AW'(cnt_m1) : AW'(idx_p1);

  always_comb begin
    if (ctl.cnt_inc) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (ctl.cnt_dec) begin
      cnt_nxt = cnt_r - CW'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  assign rd_en = ctl.rd_step | ctl.rd_idx;
  assign raddr = ctl.rd_idx ? idx_a : ptr_r;
  assign wr_en = ctl.wr_shift | ctl.wr_val;
  assign waddr = ctl.wr_shift ? wptr_r : idx_a;
  assign wdata = ctl.wr_shift ? rdata_r : val_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign val_ext = 64'(in_value);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r  <= in_command;
      idx_r <= in_index;
      val_r <= val_ext[WORD_WIDTH-1:0];
    end
    if (ctl.ptr_init) begin
      ptr_r <= ptr_start;
    end else if (ctl.rd_step) begin
      ptr_r <= is_ins ? (ptr_r - AW'(1)) : (ptr_r + AW'(1));
    end
    // the word read now lands one place over on the next cycle
    if (ctl.rd_step) begin
      wptr_r <= is_ins ? (ptr_r + AW'(1)) : (ptr_r - AW'(1));
    end
  end

  assign rd_ext = 64'(rdata_r);

  always_ff @(posedge clk) begin
    if (ctl.post) begin
      out_status_r     <= ctl.status;
      out_read_value_r <= ctl.use_rdata ? rd_ext[31:0] : 32'd0;
      out_count_r      <= 7'(cnt_nxt);
    end
  end

  assign out_status     = out_status_r;
  assign out_read_value = out_read_value_r;
  assign out_count      = out_count_r;

endmodule : pirl_dpath
`default_nettype wire

[rtl/core/pirl_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pirl_ctrl
// Sequencer for the list: checks each command, steps the shift loop and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module pirl_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  pirl_pkg::sts_t sts,
  output pirl_pkg::ctl_t ctl
);
  import pirl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SHIFT,
    S_DRAIN,
    S_WRITE,
    S_FINISH
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] status_r, status_nxt;
  logic       use_rd_r, use_rd_nxt;
  logic       pend_r, pend_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    ctl           = '0;
    state_nxt     = state_r;
    status_nxt    = status_r;
    use_rd_nxt    = use_rd_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        status_nxt = ST_OK;
        use_rd_nxt = 1'b0;
        pend_nxt   = 1'b0;
        state_nxt  = S_FINISH;
        unique case (sts.op)
          CMD_INSERT: begin
            // range check ranks above the full check
            if (sts.ins_bad) begin
              status_nxt = ST_RANGE;
            end else if (sts.full) begin
              status_nxt = ST_FULL;
            end else if (sts.shift_need) begin
              ctl.ptr_init = 1'b1;
              state_nxt    = S_SHIFT;
            end else begin
              state_nxt = S_WRITE;
            end
          end
          CMD_REMOVE: begin
            if (sts.acc_bad) begin
              status_nxt = ST_RANGE;
            end else if (sts.shift_need) begin
              ctl.ptr_init = 1'b1;
              state_nxt    = S_SHIFT;
            end else begin
              ctl.cnt_dec = 1'b1;
            end
          end
          CMD_READ: begin
            if (sts.acc_bad) begin
              status_nxt = ST_RANGE;
            end else begin
              ctl.rd_idx = 1'b1;
              use_rd_nxt = 1'b1;
            end
          end
          default: begin
            status_nxt = ST_RANGE;
          end
        endcase
      end
      S_SHIFT: begin
        // the first read has no word waiting to be written
        ctl.rd_step  = 1'b1;
        ctl.wr_shift = pend_r;
        pend_nxt     = 1'b1;
        if (sts.last_step) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        ctl.wr_shift = 1'b1;
        if (sts.op == CMD_INSERT) begin
          state_nxt = S_WRITE;
        end else begin
          ctl.cnt_dec = 1'b1;
          state_nxt   = S_FINISH;
        end
      end
      S_WRITE: begin
        ctl.wr_val  = 1'b1;
        ctl.cnt_inc = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register frees up
        if (slot_free) begin
          ctl.post      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    ctl.status    = status_r;
    ctl.use_rdata = use_rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      status_r    <= ST_OK;
      use_rd_r    <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      use_rd_r    <= use_rd_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule : pirl_ctrl
`default_nettype wire
